@@ design/dlps_pkg.sv @@
package dlps_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 8;
    localparam int TGT_W  = 12;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int SUM_W  = TGT_W + 1;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int IN_FIELDS_W  = DATA_W + LEN_W + TGT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 * DATA_W + 3 * LEN_W + CNT_W + 2 + IDX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_SEARCH     = 3'd5,
        CMD_QUERY      = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PEEK,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wentry;
        logic             re_a;
        logic [IDX_W-1:0] raddr_a;
        logic             re_b;
        logic [IDX_W-1:0] raddr_b;
    } t_mem_req;

    typedef struct packed {
        logic clr;
        logic add;
    } t_acc_ctl;

    function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

@@ design/dlps_mem.sv @@
module dlps_mem (
    input  logic               i_clk,
    input  dlps_pkg::t_mem_req i_req,
    output dlps_pkg::t_entry   o_rd_a,
    output dlps_pkg::t_entry   o_rd_b
);
    import dlps_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wentry;
        end
        if (i_req.re_a) begin
            r_rd_a <= r_mem[i_req.raddr_a];
        end
        if (i_req.re_b) begin
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

@@ design/dlps_acc.sv @@
module dlps_acc (
    input  logic                       i_clk,
    input  dlps_pkg::t_acc_ctl         i_ctl,
    input  logic [dlps_pkg::LEN_W-1:0] i_len,
    input  logic [dlps_pkg::TGT_W-1:0] i_target,
    output logic                       o_hit
);
    import dlps_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    // sum stays below target plus one length, so it never overflows
    assign n_sum = r_sum + SUM_W'(i_len);
    assign o_hit = (n_sum >= SUM_W'(i_target));

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.add) begin
            r_sum <= n_sum;
        end
    end

endmodule

@@ design/deque_with_length_prefix_search.sv @@
// push, pop, clear and query: an accepted word runs through the execute, peek and load states to its result
// search: the scan state sits between execute and peek and walks the entries, one entry per cycle through the adder
// a new word is taken only in idle, after the result of the last one is loaded into the output register
// the entry store has one write port and two registered read ports; the search runs through one accumulator
// reset: synchronous active low, clears count, front position, the sequencer and the output valid flag
// store contents are not cleared; entries read while the deque is empty are masked to zero at the output
module deque_with_length_prefix_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // entry_data, entry_len, target_len, zero pad
    input  logic [dlps_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // command
    input  logic [dlps_pkg::CMD_W-1:0]       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // removed_data, removed_len, front_data, front_len, back_data, back_len,
    // occupancy, empty, found, found_index, zero pad
    output logic [dlps_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [dlps_pkg::STAT_W-1:0]      o_m_axis_tuser
);
    import dlps_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_cmd    r_cmd;
    t_entry  r_in;
    logic [TGT_W-1:0] r_target;
    logic [IDX_W-1:0] r_front;
    logic [CNT_W-1:0] r_count;
    t_status r_status;
    t_entry  r_rem;
    logic             r_found;
    logic [IDX_W-1:0] r_fidx;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [STAT_W-1:0]      r_out_tuser;

    t_mem_req mem_req;
    t_acc_ctl acc_ctl;
    t_entry   rd_a;
    t_entry   rd_b;
    t_entry   front_e;
    t_entry   back_e;
    logic     acc_hit;
    logic     in_accept;
    logic     out_free;
    logic     full;
    logic     empty;
    logic     last;
    logic     search_go;
    logic     is_pop;
    logic [IDX_W-1:0] back_addr;
    logic [CNT_W-1:0] idx_next;
    logic [OUT_FIELDS_W-1:0] out_fields;

    dlps_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    dlps_acc u_acc (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_len    (rd_a.len),
        .i_target (r_target),
        .o_hit    (acc_hit)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign full            = (r_count == CNT_W'(DEPTH));
    assign empty           = (r_count == '0);
    assign last            = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign idx_next        = CNT_W'(r_idx) + CNT_W'(1);
    assign back_addr       = slot_add(r_front, r_count - CNT_W'(1));
    assign search_go       = (r_cmd == CMD_SEARCH) && (r_target != '0) && !empty;
    assign is_pop          = (r_cmd == CMD_POP_FRONT) || (r_cmd == CMD_POP_BACK);

    always_comb begin
        mem_req        = '0;
        mem_req.wentry = r_in;
        acc_ctl        = '0;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        mem_req.we    = !full;
                        mem_req.waddr = slot_add(r_front, CNT_W'(DEPTH - 1));
                    end
                    CMD_PUSH_BACK: begin
                        mem_req.we    = !full;
                        mem_req.waddr = slot_add(r_front, r_count);
                    end
                    CMD_POP_FRONT: begin
                        mem_req.re_a    = !empty;
                        mem_req.raddr_a = r_front;
                    end
                    CMD_POP_BACK: begin
                        mem_req.re_a    = !empty;
                        mem_req.raddr_a = back_addr;
                    end
                    CMD_SEARCH: begin
                        mem_req.re_a    = search_go;
                        mem_req.raddr_a = r_front;
                        acc_ctl.clr     = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                acc_ctl.add     = 1'b1;
                mem_req.re_a    = !(acc_hit || last);
                mem_req.raddr_a = slot_add(r_front, idx_next);
            end
            S_PEEK: begin
                mem_req.re_a    = 1'b1;
                mem_req.raddr_a = r_front;
                mem_req.re_b    = 1'b1;
                mem_req.raddr_b = back_addr;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = search_go ? S_SCAN : S_PEEK;
            end
            S_SCAN: begin
                if (acc_hit || last) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign front_e = empty ? '0 : rd_a;
    assign back_e  = empty ? '0 : rd_b;
    assign out_fields = {r_fidx, r_found, empty, r_count,
                         back_e.len, back_e.data, front_e.len, front_e.data,
                         r_rem.len, r_rem.data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_LOAD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd     <= t_cmd'(i_s_axis_tuser);
                        r_in.data <= i_s_axis_tdata[DATA_W-1:0];
                        r_in.len  <= i_s_axis_tdata[DATA_W+LEN_W-1:DATA_W];
                        r_target  <= i_s_axis_tdata[IN_FIELDS_W-1:DATA_W+LEN_W];
                    end
                end
                S_EXEC: begin
                    r_status <= STAT_OK;
                    r_found  <= 1'b0;
                    r_fidx   <= '0;
                    r_rem    <= '0;
                    r_idx    <= '0;
                    unique case (r_cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                r_status <= STAT_FULL;
                            end else begin
                                r_front <= slot_add(r_front, CNT_W'(DEPTH - 1));
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                r_status <= STAT_FULL;
                            end else begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                r_status <= STAT_EMPTY;
                            end else begin
                                r_front <= slot_add(r_front, CNT_W'(1));
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                r_status <= STAT_EMPTY;
                            end else begin
                                r_count <= r_count - CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            r_count <= '0;
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    if (acc_hit) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_idx;
                    end else if (!last) begin
                        r_idx <= idx_next[IDX_W-1:0];
                    end
                end
                S_PEEK: begin
                    if (is_pop && (r_status == STAT_OK)) begin
                        r_rem <= rd_a;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_out_tdata <= OUT_TDATA_W'(out_fields);
                        r_out_tuser <= r_status;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted word did not start execution");

    a_found_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOAD) && r_found) |-> (r_cmd == CMD_SEARCH))
        else $error("found flag outside a search");

    a_no_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_s_axis_tready)
        else $error("ready during search walk");

endmodule
